FILE: rtl/core/bgap_pkg.sv
// ----------------------------------------------------------------------------
// bgap_pkg
// Shared types, microcode and curve constants for the battery gauge block.
// ----------------------------------------------------------------------------
package bgap_pkg;

    localparam int MV_W    = 14;
    localparam int PCT_W   = 7;
    localparam int STEP_W  = 4;
    localparam int OP_W    = 4;
    localparam int COND_W  = 2;
    localparam int SEG_W   = 4;
    localparam int DIFF_W  = 8;
    localparam int NUMER_W = 11;
    localparam int PREC_W  = 14;
    localparam int PCT_SH  = 19;

    localparam logic [MV_W-1:0] FULL_SCALE_RESET = MV_W'(5160);
    localparam logic [SEG_W-1:0] LAST_BREAK      = SEG_W'(10);
    localparam logic [PCT_W-1:0] PCT_FULL        = PCT_W'(100);

    // datapath operations
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
    localparam logic [OP_W-1:0] OP_UPDATE   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV_MEAN = 4'd3;
    localparam logic [OP_W-1:0] OP_GET_MEAN = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL      = 4'd5;
    localparam logic [OP_W-1:0] OP_DIV_MV   = 4'd6;
    localparam logic [OP_W-1:0] OP_GET_MV   = 4'd7;
    localparam logic [OP_W-1:0] OP_SEG      = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV_PCT  = 4'd9;
    localparam logic [OP_W-1:0] OP_GET_PCT  = 4'd10;
    localparam logic [OP_W-1:0] OP_EMIT     = 4'd11;

    // step advance conditions
    localparam logic [COND_W-1:0] COND_ALWAYS = 2'd0;
    localparam logic [COND_W-1:0] COND_IN     = 2'd1;
    localparam logic [COND_W-1:0] COND_DIV    = 2'd2;
    localparam logic [COND_W-1:0] COND_OUT    = 2'd3;

    // program steps
    localparam logic [STEP_W-1:0] STEP_LOAD     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_UPDATE   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DIV_MEAN = 4'd2;
    localparam logic [STEP_W-1:0] STEP_GET_MEAN = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MUL      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DIV_MV   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_GET_MV   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SEG      = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DIV_PCT  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_GET_PCT  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic              jump;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            fire;
    } ctrl_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } stat_t;

    // control store: a step holds until its condition is met, then moves on
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        w.op     = OP_NONE;
        w.cond   = COND_ALWAYS;
        w.jump   = 1'b0;
        w.target = STEP_LOAD;
        case (step)
            STEP_LOAD: begin
                w.op   = OP_LOAD;
                w.cond = COND_IN;
            end
            STEP_UPDATE:   w.op = OP_UPDATE;
            STEP_DIV_MEAN: w.op = OP_DIV_MEAN;
            STEP_GET_MEAN: begin
                w.op   = OP_GET_MEAN;
                w.cond = COND_DIV;
            end
            STEP_MUL:    w.op = OP_MUL;
            STEP_DIV_MV: w.op = OP_DIV_MV;
            STEP_GET_MV: begin
                w.op   = OP_GET_MV;
                w.cond = COND_DIV;
            end
            STEP_SEG:     w.op = OP_SEG;
            STEP_DIV_PCT: w.op = OP_DIV_PCT;
            STEP_GET_PCT: begin
                w.op   = OP_GET_PCT;
                w.cond = COND_DIV;
            end
            STEP_EMIT: begin
                w.op     = OP_EMIT;
                w.cond   = COND_OUT;
                w.jump   = 1'b1;
                w.target = STEP_LOAD;
            end
            default: begin
                w.jump   = 1'b1;
                w.target = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

    // discharge curve breakpoints in mV, one per 10 percent
    function automatic logic [MV_W-1:0] brk_mv(input logic [SEG_W-1:0] idx);
        logic [MV_W-1:0] v;
        case (idx)
            4'd0:    v = MV_W'(3300);
            4'd1:    v = MV_W'(3450);
            4'd2:    v = MV_W'(3550);
            4'd3:    v = MV_W'(3650);
            4'd4:    v = MV_W'(3700);
            4'd5:    v = MV_W'(3750);
            4'd6:    v = MV_W'(3800);
            4'd7:    v = MV_W'(3850);
            4'd8:    v = MV_W'(3980);
            4'd9:    v = MV_W'(4100);
            4'd10:   v = MV_W'(4200);
            default: v = MV_W'(4200);
        endcase
        return v;
    endfunction

    // ceil(2^PCT_SH / span) for the segment that ends at breakpoint idx
    function automatic logic [PREC_W-1:0] seg_rec(input logic [SEG_W-1:0] idx);
        logic [PREC_W-1:0] r;
        case (idx)
            4'd1:                    r = PREC_W'(3496);   // 150 mV span
            4'd2, 4'd3, 4'd10:       r = PREC_W'(5243);   // 100 mV span
            4'd4, 4'd5, 4'd6, 4'd7:  r = PREC_W'(10486);  // 50 mV span
            4'd8:                    r = PREC_W'(4033);   // 130 mV span
            4'd9:                    r = PREC_W'(4370);   // 120 mV span
            default:                 r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/bgap_div.sv
// ----------------------------------------------------------------------------
// bgap_div
// Division by a constant as one registered reciprocal multiplication.
// ----------------------------------------------------------------------------
module bgap_div #(
    parameter int NUM_W = 27,
    parameter int REC_W = 28
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [NUM_W-1:0]       num,
    input  logic [REC_W-1:0]       rec,
    output logic                   done,
    output logic [NUM_W+REC_W-1:0] prod
);

    localparam int PROD_W = NUM_W + REC_W;

    logic              done_reg, done_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // quotient is taken from the product by a fixed shift downstream
    always_comb begin
        done_next = start;
        prod_next = prod_reg;
        if (start) begin
            prod_next = {{REC_W{1'b0}}, num} * {{NUM_W{1'b0}}, rec};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

FILE: rtl/core/bgap_dp.sv
// ----------------------------------------------------------------------------
// bgap_dp
// Datapath: sample history, running sum, scaling, curve lookup, result reg.
// ----------------------------------------------------------------------------
module bgap_dp #(
    parameter int TAPS        = 10,
    parameter int SAMPLE_BITS = 13
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bgap_pkg::ctrl_t              ctrl,
    output bgap_pkg::stat_t              stat,
    input  logic [SAMPLE_BITS-1:0]       raw_sample,
    input  logic                         cfg_wr_en,
    input  logic [bgap_pkg::MV_W-1:0]    cfg_wr_data,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [SAMPLE_BITS-1:0]       m_mean_raw,
    output logic [bgap_pkg::MV_W-1:0]    m_battery_mv,
    output logic [bgap_pkg::PCT_W-1:0]   m_charge_percent
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(TAPS);
    localparam int NUM_W  = SAMPLE_BITS + bgap_pkg::MV_W;
    localparam int PTR_W  = $clog2(TAPS);
    localparam int MV_W   = bgap_pkg::MV_W;
    localparam int PCT_W  = bgap_pkg::PCT_W;
    localparam int SEG_W  = bgap_pkg::SEG_W;
    localparam int REC_W  = NUM_W + 1;
    localparam int PROD_W = NUM_W + REC_W;

    // reciprocal shifts chosen so the truncated product equals the quotient
    localparam int MEAN_SH = SUM_W + PTR_W + 1;
    localparam int MV_SH   = NUM_W + SAMPLE_BITS;
    localparam logic [63:0] ADC_MAX  = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam logic [63:0] MEAN_REC = ((64'd1 << MEAN_SH) + 64'(TAPS) - 64'd1) / 64'(TAPS);
    localparam logic [63:0] MV_REC   = ((64'd1 << MV_SH) + ADC_MAX - 64'd1) / ADC_MAX;

    logic [SAMPLE_BITS-1:0] hist_mem [TAPS];
    logic [TAPS-1:0]        vld_reg, vld_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [MV_W-1:0]        fs_reg, fs_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    logic [SAMPLE_BITS-1:0]           sample_reg;
    logic [SAMPLE_BITS-1:0]           old_reg;
    logic                             old_vld_reg;
    logic [SAMPLE_BITS-1:0]           mean_reg;
    logic [NUM_W-1:0]                 prod_reg;
    logic [MV_W-1:0]                  mv_reg;
    logic [PCT_W-1:0]                 base_reg;
    logic [bgap_pkg::NUMER_W-1:0]     numer_reg;
    logic [bgap_pkg::PREC_W-1:0]      rec_reg;
    logic [PCT_W-1:0]                 pct_reg;
    logic [SAMPLE_BITS-1:0]           out_mean_reg;
    logic [MV_W-1:0]                  out_mv_reg;
    logic [PCT_W-1:0]                 out_pct_reg;

    logic                             div_start;
    logic [NUM_W-1:0]                 div_num;
    logic [REC_W-1:0]                 div_rec;
    logic                             div_done;
    logic [PROD_W-1:0]                div_prod;

    logic [SEG_W-1:0]                 seg_k;
    logic [SEG_W-1:0]                 seg_b;
    logic [MV_W-1:0]                  seg_lo;
    logic [MV_W-1:0]                  seg_diff_w;
    logic [bgap_pkg::DIFF_W-1:0]      seg_diff;
    logic [PCT_W-1:0]                 seg_base;
    logic [bgap_pkg::NUMER_W-1:0]     seg_numer;
    logic [bgap_pkg::PREC_W-1:0]      seg_prec;
    logic                             seg_top;
    logic [SAMPLE_BITS-1:0]           old_val;

    logic op_load, op_update, op_get_mean, op_mul, op_get_mv, op_seg, op_get_pct;
    logic op_emit;

    always_comb begin
        op_load     = ctrl.fire && (ctrl.op == bgap_pkg::OP_LOAD);
        op_update   = ctrl.fire && (ctrl.op == bgap_pkg::OP_UPDATE);
        op_get_mean = ctrl.fire && (ctrl.op == bgap_pkg::OP_GET_MEAN);
        op_mul      = ctrl.fire && (ctrl.op == bgap_pkg::OP_MUL);
        op_get_mv   = ctrl.fire && (ctrl.op == bgap_pkg::OP_GET_MV);
        op_seg      = ctrl.fire && (ctrl.op == bgap_pkg::OP_SEG);
        op_get_pct  = ctrl.fire && (ctrl.op == bgap_pkg::OP_GET_PCT);
        op_emit     = ctrl.fire && (ctrl.op == bgap_pkg::OP_EMIT);
    end

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_rec   = '0;
        case (ctrl.op)
            bgap_pkg::OP_DIV_MEAN: begin
                div_start = ctrl.fire;
                div_num   = NUM_W'(sum_reg);
                div_rec   = REC_W'(MEAN_REC);
            end
            bgap_pkg::OP_DIV_MV: begin
                div_start = ctrl.fire;
                div_num   = prod_reg;
                div_rec   = REC_W'(MV_REC);
            end
            bgap_pkg::OP_DIV_PCT: begin
                div_start = ctrl.fire;
                div_num   = NUM_W'(numer_reg);
                div_rec   = REC_W'(rec_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    bgap_div #(
        .NUM_W (NUM_W),
        .REC_W (REC_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .rec     (div_rec),
        .done    (div_done),
        .prod    (div_prod)
    );

    // curve segment: highest breakpoint strictly below mv
    always_comb begin
        seg_k = '0;
        for (int k = 1; k <= 10; k++) begin
            if (mv_reg > bgap_pkg::brk_mv(SEG_W'(k - 1))) begin
                seg_k = SEG_W'(k);
            end
        end
        seg_top    = mv_reg >= bgap_pkg::brk_mv(bgap_pkg::LAST_BREAK);
        seg_b      = seg_k - SEG_W'(1);
        seg_lo     = bgap_pkg::brk_mv(seg_b);
        seg_diff_w = mv_reg - seg_lo;
        seg_prec   = bgap_pkg::seg_rec(seg_k);
        if (seg_top) begin
            seg_base = bgap_pkg::PCT_FULL;
            seg_diff = '0;
        end else if (seg_k == '0) begin
            seg_base = '0;
            seg_diff = '0;
        end else begin
            seg_base = {seg_b, 3'b000} + {2'b00, seg_b, 1'b0};
            seg_diff = seg_diff_w[bgap_pkg::DIFF_W-1:0];
        end
        // times ten as two shifts
        seg_numer = {seg_diff, 3'b000} + {2'b00, seg_diff, 1'b0};
    end

    assign old_val = old_vld_reg ? old_reg : '0;

    always_comb begin
        vld_next = vld_reg;
        ptr_next = ptr_reg;
        sum_next = sum_reg;
        if (op_update) begin
            vld_next[ptr_reg] = 1'b1;
            ptr_next = (ptr_reg == PTR_W'(TAPS - 1)) ? '0 : ptr_reg + PTR_W'(1);
            sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(sample_reg);
        end
        fs_next = cfg_wr_en ? cfg_wr_data : fs_reg;
        if (op_emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            ptr_reg      <= '0;
            sum_reg      <= '0;
            fs_reg       <= bgap_pkg::FULL_SCALE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            vld_reg      <= vld_next;
            ptr_reg      <= ptr_next;
            sum_reg      <= sum_next;
            fs_reg       <= fs_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // history ring, oldest entry sits at the write pointer
    always_ff @(posedge aclk) begin
        if (op_load) begin
            old_reg <= hist_mem[ptr_reg];
        end
        if (op_update) begin
            hist_mem[ptr_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (op_load) begin
            sample_reg  <= raw_sample;
            old_vld_reg <= vld_reg[ptr_reg];
        end
        if (op_get_mean) begin
            mean_reg <= div_prod[MEAN_SH +: SAMPLE_BITS];
        end
        if (op_mul) begin
            prod_reg <= NUM_W'(mean_reg) * NUM_W'(fs_reg);
        end
        if (op_get_mv) begin
            mv_reg <= div_prod[MV_SH +: MV_W];
        end
        if (op_seg) begin
            base_reg  <= seg_base;
            numer_reg <= seg_numer;
            rec_reg   <= seg_prec;
        end
        if (op_get_pct) begin
            pct_reg <= base_reg + div_prod[bgap_pkg::PCT_SH +: PCT_W];
        end
        if (op_emit) begin
            out_mean_reg <= mean_reg;
            out_mv_reg   <= mv_reg;
            out_pct_reg  <= pct_reg;
        end
    end

    assign stat.div_done    = div_done;
    assign stat.out_free    = !m_tvalid_reg || m_tready;
    assign m_tvalid         = m_tvalid_reg;
    assign m_mean_raw       = out_mean_reg;
    assign m_battery_mv     = out_mv_reg;
    assign m_charge_percent = out_pct_reg;

endmodule

FILE: rtl/core/bgap_seq.sv
// ----------------------------------------------------------------------------
// bgap_seq
// Step counter over the microcode store, with wait and jump handling.
// ----------------------------------------------------------------------------
module bgap_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  bgap_pkg::stat_t stat,
    output bgap_pkg::ctrl_t ctrl,
    output logic            in_ready
);

    logic [bgap_pkg::STEP_W-1:0] step_reg, step_next;
    bgap_pkg::uword_t            word;
    logic                        met;

    always_comb begin
        word = bgap_pkg::ucode(step_reg);
        case (word.cond)
            bgap_pkg::COND_ALWAYS: met = 1'b1;
            bgap_pkg::COND_IN:     met = in_valid && aresetn;
            bgap_pkg::COND_DIV:    met = stat.div_done;
            bgap_pkg::COND_OUT:    met = stat.out_free;
            default:               met = 1'b1;
        endcase
        if (!met) begin
            step_next = step_reg;
        end else if (word.jump) begin
            step_next = word.target;
        end else begin
            step_next = step_reg + bgap_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= bgap_pkg::STEP_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

    assign ctrl.op   = word.op;
    assign ctrl.fire = met;
    assign in_ready  = aresetn && (word.cond == bgap_pkg::COND_IN);

endmodule

FILE: rtl/core/battery_gauge_average_percent_unit.sv
// ----------------------------------------------------------------------------
// battery_gauge_average_percent_unit
// Moving-average battery gauge: ADC samples in, mean, millivolts and percent out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one ADC sample per transaction; m_* returns one result per
//   sample: the truncated mean of the last TAPS samples, the battery voltage
//   in mV and the state of charge in percent from an eleven-point curve.
//   cfg_wr_en/cfg_wr_data set the full-scale millivolts; write only when idle.
// Timing:
//   a small microcoded sequencer steps one sample through a plain datapath
//   in eleven steps; the divisions by TAPS, by the ADC full-scale code and
//   by each curve segment span are reciprocal multiplications through one
//   shared registered multiplier. A new sample is accepted only after the
//   previous one has reached the output register.
// Reset:
//   the history reads as zeros and the sum clears at once; full scale returns
//   to 5160 mV. No sweep is needed, the block is ready right after reset.
// Stall:
//   the result waits in an output register; the next sample is accepted and
//   processed meanwhile, and the sequencer only holds at its last step while
//   the previous result is still unclaimed.
// ----------------------------------------------------------------------------
module battery_gauge_average_percent_unit #(
    parameter int TAPS        = 10,
    parameter int SAMPLE_BITS = 13
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [SAMPLE_BITS-1:0] raw_sample, zero padded to bytes
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // mean_raw, battery_mv (14), charge_percent (7) from bit 0 up, zero padded
    output logic [((SAMPLE_BITS + 21 + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                      cfg_wr_en,
    input  logic [13:0]               cfg_wr_data
);

    localparam int OUT_W = ((SAMPLE_BITS + 21 + 7) / 8) * 8;

    bgap_pkg::ctrl_t ctrl;
    bgap_pkg::stat_t stat;

    logic [SAMPLE_BITS-1:0]           mean_raw;
    logic [bgap_pkg::MV_W-1:0]        battery_mv;
    logic [bgap_pkg::PCT_W-1:0]       charge_percent;

    bgap_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_ready (s_tready)
    );

    bgap_dp #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .stat             (stat),
        .raw_sample       (s_tdata[SAMPLE_BITS-1:0]),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .m_mean_raw       (mean_raw),
        .m_battery_mv     (battery_mv),
        .m_charge_percent (charge_percent)
    );

    assign m_tdata = OUT_W'({charge_percent, battery_mv, mean_raw});

endmodule
